// ===== src/mexp_pkg.sv =====
// shared constants for the modular exponentiation block
package mexp_pkg;

  // default datapath width of the arithmetic
  localparam int WORD_BITS_DEFAULT = 32;

  // fixed widths of the item ports
  localparam int BASE_BITS   = 32;
  localparam int RESULT_BITS = 32;

  // register indexes on the configuration port
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  // status of the shared multiplier as seen by the sequencer
  typedef struct packed {
    logic running;
    logic done;
  } mul_status_t;

endpackage

// ===== src/modular_exponentiation.sv =====
// Modular exponentiation: power_result = base_value ^ exponent mod modulus.
// Configuration: apb-style port, modulus at byte address 0 (reset 2),
// exponent at byte address 4, 8 when WORD_BITS > 32 (reset 1); write only
// while busy is low. A modulus of zero means arithmetic modulo 2^WORD_BITS.
// Input: a beat is taken when start is high and busy is low; busy then
// stays high until a result that needs the multiplier is out; one item at a time.
// Output: power_result is valid for the single cycle in which done is high;
// the receiver cannot stall and must take it in that cycle.
// Sequence: exponent zero or modulus one answer in the cycle after the beat.
// Otherwise the base is first reduced, then right-to-left square and
// multiply runs over the exponent bits up to its highest set bit. Every
// multiply goes through one bit-serial modular multiplier that does one
// add-and-reduce per cycle, and each exponent bit passes through one
// decision state of the sequencer.
// Reset: registers return to their defaults, the block is idle, no result.
module modular_exponentiation #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT,
  localparam int BUS_BITS  = (WORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_BITS = (WORD_BITS > 32) ? 4 : 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [mexp_pkg::BASE_BITS-1:0]   base_value,
  output logic                             done,
  output logic [mexp_pkg::RESULT_BITS-1:0] power_result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ADDR_BITS-1:0]             paddr,
  input  logic [BUS_BITS-1:0]              pwdata,
  output logic [BUS_BITS-1:0]              prdata,
  output logic                             pready
);
  import mexp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_MULT   = 3'd3;
  localparam logic [2:0] S_SQUARE = 3'd4;

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] exponent;

  logic [2:0]           state;
  logic [WORD_BITS-1:0] m_reg;
  logic [WORD_BITS-1:0] e_reg;
  logic [WORD_BITS-1:0] e_shift;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] sq;
  logic                 mul_start;
  logic [WORD_BITS-1:0] mul_a;
  logic [WORD_BITS-1:0] mul_b;
  logic [WORD_BITS-1:0] product;
  mul_status_t          mul_stat;

  mexp_regs #(.WORD_BITS(WORD_BITS)) u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .modulus  (modulus),
    .exponent (exponent)
  );

  mexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .modulus (m_reg),
    .product (product),
    .status  (mul_stat)
  );

  assign busy    = (state != S_IDLE);
  assign e_shift = {1'b0, e_reg[WORD_BITS-1:1]};

  // square and multiply sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      mul_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      mul_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            m_reg <= modulus;
            e_reg <= exponent;
            if (exponent == '0) begin
              power_result <= RESULT_BITS'(1);
              done         <= 1'b1;
            end else if (modulus == WORD_BITS'(1)) begin
              power_result <= '0;
              done         <= 1'b1;
            end else begin
              // base mod m as 1 * base through the multiplier
              mul_a     <= WORD_BITS'(1);
              mul_b     <= WORD_BITS'(base_value);
              mul_start <= 1'b1;
              state     <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mul_stat.done) begin
            sq    <= product;
            acc   <= WORD_BITS'(1);
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (e_reg == '0) begin
            power_result <= RESULT_BITS'(acc);
            done         <= 1'b1;
            state        <= S_IDLE;
          end else if (e_reg[0]) begin
            mul_a     <= acc;
            mul_b     <= sq;
            mul_start <= 1'b1;
            state     <= S_MULT;
          end else begin
            e_reg     <= e_shift;
            mul_a     <= sq;
            mul_b     <= sq;
            mul_start <= 1'b1;
            state     <= S_SQUARE;
          end
        end
        S_MULT: begin
          if (mul_stat.done) begin
            acc   <= product;
            e_reg <= e_shift;
            if (e_shift == '0) begin
              power_result <= RESULT_BITS'(product);
              done         <= 1'b1;
              state        <= S_IDLE;
            end else begin
              mul_a     <= sq;
              mul_b     <= sq;
              mul_start <= 1'b1;
              state     <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          if (mul_stat.done) begin
            sq    <= product;
            state <= S_STEP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result beat only leaves with the sequencer back at idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // multiplier finishes only while the sequencer waits for it
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == S_REDUCE || state == S_MULT || state == S_SQUARE))
    else $error("multiplier done outside a wait state");

  // no new multiply while one is running
  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.running)
    else $error("multiply started while unit busy");

  // captured modulus holds for the whole item
  a_mod_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> $stable(m_reg))
    else $error("modulus changed mid item");

  // running square and accumulator stay reduced
  a_sq_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && m_reg != '0) |-> (sq < m_reg && acc < m_reg))
    else $error("operand not reduced");

endmodule

// ===== src/mexp_regs.sv =====
// configuration registers behind the apb-style port
module mexp_regs #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT,
  localparam int BUS_BITS  = (WORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_BITS = (WORD_BITS > 32) ? 4 : 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [BUS_BITS-1:0]  pwdata,
  output logic [BUS_BITS-1:0]  prdata,
  output logic                 pready,
  output logic [WORD_BITS-1:0] modulus,
  output logic [WORD_BITS-1:0] exponent
);
  import mexp_pkg::*;

  logic reg_index;
  logic wr_beat;

  // register index sits in the top address bit
  assign reg_index = paddr[ADDR_BITS-1];
  assign wr_beat   = psel && penable && pwrite;
  assign pready    = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WORD_BITS'(2);
      exponent <= WORD_BITS'(1);
    end else if (wr_beat) begin
      unique case (reg_index)
        REG_MODULUS:  modulus  <= pwdata[WORD_BITS-1:0];
        REG_EXPONENT: exponent <= pwdata[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    unique case (reg_index)
      REG_MODULUS:  prdata = BUS_BITS'(modulus);
      REG_EXPONENT: prdata = BUS_BITS'(exponent);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== src/mexp_mulmod.sv =====
// bit-serial modular multiplier built round one shared add-and-reduce unit
module mexp_mulmod #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [WORD_BITS-1:0]      mul_a,
  input  logic [WORD_BITS-1:0]      mul_b,
  input  logic [WORD_BITS-1:0]      modulus,
  output logic [WORD_BITS-1:0]      product,
  output mexp_pkg::mul_status_t     status
);
  import mexp_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] a_reg;
  logic [WORD_BITS-1:0] b_reg;
  logic [CNT_BITS-1:0]  bit_cnt;
  logic                 add_phase;
  logic                 running;
  logic                 done;

  logic [WORD_BITS-1:0] add_y;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   diff;
  logic                 over;
  logic [WORD_BITS-1:0] add_res;
  logic                 last_bit;

  // shared unit: (acc + y) mod m, modulus zero wraps at the word width
  assign add_y   = add_phase ? a_reg : acc;
  assign sum     = {1'b0, acc} + {1'b0, add_y};
  assign diff    = sum - {1'b0, modulus};
  assign over    = (modulus != '0) && (sum >= {1'b0, modulus});
  assign add_res = over ? diff[WORD_BITS-1:0] : sum[WORD_BITS-1:0];

  assign last_bit = (bit_cnt == CNT_BITS'(WORD_BITS - 1));

  // multiplier bits from the top: double, then add the multiplicand on a one
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        acc       <= '0;
        a_reg     <= mul_a;
        b_reg     <= mul_b;
        bit_cnt   <= '0;
        add_phase <= 1'b0;
      end else if (running) begin
        acc <= add_res;
        if (!add_phase && b_reg[WORD_BITS-1]) begin
          add_phase <= 1'b1;
        end else begin
          add_phase <= 1'b0;
          b_reg     <= {b_reg[WORD_BITS-2:0], 1'b0};
          bit_cnt   <= bit_cnt + CNT_BITS'(1);
          if (last_bit) begin
            running <= 1'b0;
            done    <= 1'b1;
          end
        end
      end
    end
  end

  assign product        = acc;
  assign status.running = running;
  assign status.done    = done;

endmodule
